@@ hdl/pwbr_pkg.sv @@
// Package: shared types, frame layout constants and codes for the pulse-width bit receiver.
`timescale 1ns / 1ps
`default_nettype none

package pwbr_pkg;

    // Widths of the fields and of the configuration port.
    localparam int TICK_W    = 20;
    localparam int KIND_W    = 3;
    localparam int INDEX_W   = 8;
    localparam int LENGTH_W  = 8;
    localparam int POS_W     = 9;
    localparam int CFG_IDX_W = 2;

    // Frame layout, in bit positions counted from the first bit after the start bit.
    localparam int LEN_FIELD_OFFSET = 34;
    localparam int LEN_FIELD_BITS   = 8;
    localparam int DATA_OFFSET      = 44;
    localparam int DATA_FIELD_BITS  = 10;
    localparam int MAX_FRAME_BITS   = 256;

    // Wide enough for DATA_OFFSET + DATA_FIELD_BITS * 255 over the whole parameter range.
    localparam int TOTAL_W = 13;

    // Register reset values.
    localparam logic [TICK_W-1:0] TIMEOUT_RESET   = '1;
    localparam logic [TICK_W-1:0] START_MIN_RESET = '0;
    localparam logic [TICK_W-1:0] BIT_MAX_RESET   = '1;
    localparam logic [TICK_W-1:0] BIT_SPLIT_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TIMEOUT   = 2'd0,
        REG_START_MIN = 2'd1,
        REG_BIT_MAX   = 2'd2,
        REG_BIT_SPLIT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_START   = 2'd1,
        MODE_WAIT    = 2'd2,
        MODE_MEASURE = 2'd3
    } rx_mode_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE       = 3'd0,
        KIND_BIT        = 3'd1,
        KIND_LAST_BIT   = 3'd2,
        KIND_BIT_ERROR  = 3'd3,
        KIND_TIMEOUT    = 3'd4,
        KIND_START_REJ  = 3'd5,
        KIND_OVERLENGTH = 3'd6
    } event_kind_t;

    typedef struct packed {
        logic [TICK_W-1:0] timeout_ticks;
        logic [TICK_W-1:0] start_min_ticks;
        logic [TICK_W-1:0] bit_max_ticks;
        logic [TICK_W-1:0] bit_split_ticks;
    } cfg_t;

    typedef struct packed {
        logic              edge_rising;
        logic [TICK_W-1:0] elapsed_ticks;
        logic              timer_expired;
    } edge_item_t;

    typedef struct packed {
        event_kind_t         event_kind;
        logic                bit_value;
        logic [INDEX_W-1:0]  bit_index;
        logic [LENGTH_W-1:0] data_length;
    } rx_result_t;

endpackage

`default_nettype wire

@@ hdl/pwbr_cfg_regs.sv @@
// Configuration register file of the pulse-width bit receiver.
`timescale 1ns / 1ps
`default_nettype none

module pwbr_cfg_regs (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [pwbr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pwbr_pkg::TICK_W-1:0]       cfg_wdata,
    output pwbr_pkg::cfg_t                         cfg
);

    pwbr_pkg::cfg_t cfg_reg;
    pwbr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (pwbr_pkg::cfg_reg_t'(cfg_index))
                pwbr_pkg::REG_TIMEOUT:   cfg_next.timeout_ticks   = cfg_wdata;
                pwbr_pkg::REG_START_MIN: cfg_next.start_min_ticks = cfg_wdata;
                pwbr_pkg::REG_BIT_MAX:   cfg_next.bit_max_ticks   = cfg_wdata;
                pwbr_pkg::REG_BIT_SPLIT: cfg_next.bit_split_ticks = cfg_wdata;
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_ticks   <= pwbr_pkg::TIMEOUT_RESET;
            cfg_reg.start_min_ticks <= pwbr_pkg::START_MIN_RESET;
            cfg_reg.bit_max_ticks   <= pwbr_pkg::BIT_MAX_RESET;
            cfg_reg.bit_split_ticks <= pwbr_pkg::BIT_SPLIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ hdl/pwbr_decoder.sv @@
// Receive state machine: turns one edge event into one result and updates the frame state.
`timescale 1ns / 1ps
`default_nettype none

module pwbr_decoder (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  pwbr_pkg::cfg_t             cfg,
    input  pwbr_pkg::edge_item_t       item,
    input  wire logic                  advance,
    output pwbr_pkg::rx_result_t       result
);

    pwbr_pkg::rx_mode_t                 mode_reg, mode_next;
    logic [pwbr_pkg::POS_W-1:0]         pos_reg, pos_next;
    logic [pwbr_pkg::LENGTH_W-1:0]      len_reg, len_next;

    logic                               abort;
    logic                               long_pulse;
    logic                               bit_val;
    logic                               in_len_field;
    logic                               past_len_field;
    logic [pwbr_pkg::POS_W-1:0]         pos_rel;
    logic [pwbr_pkg::LENGTH_W-1:0]      len_shift;
    logic [pwbr_pkg::LENGTH_W-1:0]      len_with_bit;
    logic [pwbr_pkg::TOTAL_W-1:0]       frame_total;
    logic                               last_bit;

    assign abort = item.timer_expired || (item.elapsed_ticks > cfg.timeout_ticks);
    assign long_pulse = item.elapsed_ticks > cfg.bit_max_ticks;
    // A low pulse up to the split point is a one, a longer one a zero.
    assign bit_val = !(item.elapsed_ticks > cfg.bit_split_ticks);

    assign in_len_field = (pos_reg >= pwbr_pkg::POS_W'(pwbr_pkg::LEN_FIELD_OFFSET)) &&
        (pos_reg < pwbr_pkg::POS_W'(pwbr_pkg::LEN_FIELD_OFFSET + pwbr_pkg::LEN_FIELD_BITS));
    assign past_len_field =
        pos_reg >= pwbr_pkg::POS_W'(pwbr_pkg::LEN_FIELD_OFFSET + pwbr_pkg::LEN_FIELD_BITS);

    // The length field arrives MSB first.
    assign pos_rel   = pos_reg - pwbr_pkg::POS_W'(pwbr_pkg::LEN_FIELD_OFFSET);
    assign len_shift = pwbr_pkg::LENGTH_W'(pwbr_pkg::LEN_FIELD_BITS - 1) -
                       pos_rel[pwbr_pkg::LENGTH_W-1:0];
    assign len_with_bit = in_len_field ?
        (len_reg | (pwbr_pkg::LENGTH_W'(bit_val) << len_shift)) : len_reg;

    assign frame_total = pwbr_pkg::TOTAL_W'(pwbr_pkg::DATA_OFFSET) +
        pwbr_pkg::TOTAL_W'(pwbr_pkg::DATA_FIELD_BITS) * pwbr_pkg::TOTAL_W'(len_reg);
    assign last_bit = past_len_field &&
        ((pwbr_pkg::TOTAL_W'(pos_reg) + pwbr_pkg::TOTAL_W'(1)) == frame_total);

    always_comb begin
        pwbr_pkg::rx_mode_t mode_eff;
        mode_eff  = mode_reg;
        mode_next = mode_reg;
        pos_next  = pos_reg;
        len_next  = len_reg;
        result    = '0;
        result.event_kind = pwbr_pkg::KIND_NONE;

        // A timeout drops the frame; the same edge is then handled from idle.
        if (abort) begin
            mode_eff  = pwbr_pkg::MODE_IDLE;
            mode_next = pwbr_pkg::MODE_IDLE;
            pos_next  = '0;
            len_next  = '0;
            result.event_kind = pwbr_pkg::KIND_TIMEOUT;
        end

        case (mode_eff)
            pwbr_pkg::MODE_IDLE: begin
                if (!item.edge_rising) begin
                    mode_next = pwbr_pkg::MODE_START;
                end
            end
            pwbr_pkg::MODE_START: begin
                if (item.edge_rising) begin
                    pos_next = '0;
                    len_next = '0;
                    if (item.elapsed_ticks < cfg.start_min_ticks) begin
                        mode_next = pwbr_pkg::MODE_IDLE;
                        result.event_kind = pwbr_pkg::KIND_START_REJ;
                    end else begin
                        mode_next = pwbr_pkg::MODE_WAIT;
                    end
                end
            end
            pwbr_pkg::MODE_WAIT: begin
                if (item.edge_rising || long_pulse) begin
                    mode_next = pwbr_pkg::MODE_IDLE;
                    pos_next  = '0;
                    len_next  = '0;
                    result.event_kind = pwbr_pkg::KIND_BIT_ERROR;
                end else begin
                    mode_next = pwbr_pkg::MODE_MEASURE;
                end
            end
            pwbr_pkg::MODE_MEASURE: begin
                if (!item.edge_rising || long_pulse) begin
                    mode_next = pwbr_pkg::MODE_IDLE;
                    pos_next  = '0;
                    len_next  = '0;
                    result.event_kind = pwbr_pkg::KIND_BIT_ERROR;
                end else if (pos_reg >= pwbr_pkg::POS_W'(pwbr_pkg::MAX_FRAME_BITS)) begin
                    mode_next = pwbr_pkg::MODE_IDLE;
                    pos_next  = '0;
                    len_next  = '0;
                    result.event_kind = pwbr_pkg::KIND_OVERLENGTH;
                end else begin
                    result.event_kind  = last_bit ? pwbr_pkg::KIND_LAST_BIT : pwbr_pkg::KIND_BIT;
                    result.bit_value   = bit_val;
                    result.bit_index   = pos_reg[pwbr_pkg::INDEX_W-1:0];
                    result.data_length = len_with_bit;
                    if (last_bit) begin
                        mode_next = pwbr_pkg::MODE_IDLE;
                        pos_next  = '0;
                        len_next  = '0;
                    end else begin
                        mode_next = pwbr_pkg::MODE_WAIT;
                        pos_next  = pos_reg + pwbr_pkg::POS_W'(1);
                        len_next  = len_with_bit;
                    end
                end
            end
            default: begin
                mode_next = pwbr_pkg::MODE_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= pwbr_pkg::MODE_IDLE;
            pos_reg  <= '0;
            len_reg  <= '0;
        end else if (advance) begin
            mode_reg <= mode_next;
            pos_reg  <= pos_next;
            len_reg  <= len_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/pulse_width_bus_bit_receiver.sv @@
// Top level of the pulse-width bus bit receiver: input stage, decoder and result stage.
`timescale 1ns / 1ps
`default_nettype none

//  Channel   | Handshake           | Payload
//  ----------+---------------------+-----------------------------------------------------
//  s_ (edge) | s_valid / s_ready   | s_edge_rising, s_elapsed_ticks, s_timer_expired
//  m_ (rslt) | m_valid / m_ready   | m_event_kind, m_bit_value, m_bit_index, m_data_length
//  cfg       | cfg_wr_en           | cfg_index, cfg_wdata (write only, no wait)
//
// One edge transfer in and one result transfer out per cycle while m_ready stays high.
// The decoder evaluates the edge held in the input register in one pass and loads the
// result register, which offers the result on the m_ channel. Both stages move when the
// stage after them is empty or being drained, so a stall on m_ready holds the result and
// at most one more edge before s_ready drops. Synchronous active-low reset empties both
// stages, idles the receiver and loads register reset values.

module pulse_width_bus_bit_receiver (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,

    input  wire logic                               cfg_wr_en,
    input  wire logic [pwbr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pwbr_pkg::TICK_W-1:0]        cfg_wdata,

    input  wire logic                               s_valid,
    output      logic                               s_ready,
    input  wire logic                               s_edge_rising,
    input  wire logic [pwbr_pkg::TICK_W-1:0]        s_elapsed_ticks,
    input  wire logic                               s_timer_expired,

    output      logic                               m_valid,
    input  wire logic                               m_ready,
    output      logic [pwbr_pkg::KIND_W-1:0]        m_event_kind,
    output      logic                               m_bit_value,
    output      logic [pwbr_pkg::INDEX_W-1:0]       m_bit_index,
    output      logic [pwbr_pkg::LENGTH_W-1:0]      m_data_length
);

    pwbr_pkg::cfg_t          cfg;
    pwbr_pkg::edge_item_t    item_reg;
    pwbr_pkg::rx_result_t    result;
    pwbr_pkg::rx_result_t    result_reg;
    logic                    in_valid_reg, in_valid_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_free;
    logic                    advance;

    pwbr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The result register can take a new value when it is empty or its transfer completes.
    assign out_free = !out_valid_reg || m_ready;
    // The held edge is decoded, and the frame state updated, in the cycle it moves on.
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;

    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = out_free ? in_valid_reg : out_valid_reg;

    pwbr_decoder u_decoder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .item    (item_reg),
        .advance (advance),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; the valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.edge_rising   <= s_edge_rising;
            item_reg.elapsed_ticks <= s_elapsed_ticks;
            item_reg.timer_expired <= s_timer_expired;
        end
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_event_kind  = result_reg.event_kind;
    assign m_bit_value   = result_reg.bit_value;
    assign m_bit_index   = result_reg.bit_index;
    assign m_data_length = result_reg.data_length;

endmodule

`default_nettype wire

@@ hdl/pwbr_checker.sv @@
// Port-level checks for the pulse-width bit receiver, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module pwbr_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [pwbr_pkg::KIND_W-1:0]        m_event_kind,
    input wire logic                               m_bit_value,
    input wire logic [pwbr_pkg::INDEX_W-1:0]       m_bit_index,
    input wire logic [pwbr_pkg::LENGTH_W-1:0]      m_data_length
);

    logic is_bit;
    logic [pwbr_pkg::TOTAL_W-1:0] last_total;

    assign is_bit = (m_event_kind == pwbr_pkg::KIND_BIT) ||
                    (m_event_kind == pwbr_pkg::KIND_LAST_BIT);
    assign last_total = pwbr_pkg::TOTAL_W'(pwbr_pkg::DATA_OFFSET) +
        pwbr_pkg::TOTAL_W'(pwbr_pkg::DATA_FIELD_BITS) * pwbr_pkg::TOTAL_W'(m_data_length);

    // Reset empties the result stage.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result transfer holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_kind) && $stable(m_bit_value) &&
        $stable(m_bit_index) && $stable(m_data_length))
        else $error("result changed while stalled");

    // Only bit results carry a value, position and length.
    a_nonbit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !is_bit |-> !m_bit_value && m_bit_index == '0 && m_data_length == '0)
        else $error("non-bit result carries bit fields");

    // The last bit sits exactly where the gathered length puts the frame end.
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == pwbr_pkg::KIND_LAST_BIT |->
        pwbr_pkg::TOTAL_W'(m_bit_index) + pwbr_pkg::TOTAL_W'(1) == last_total)
        else $error("last bit flagged at wrong position");

    // A bit before the length field is complete cannot end the frame.
    a_last_after_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_event_kind == pwbr_pkg::KIND_LAST_BIT |->
        m_bit_index >= pwbr_pkg::INDEX_W'(pwbr_pkg::LEN_FIELD_OFFSET + pwbr_pkg::LEN_FIELD_BITS))
        else $error("last bit flagged inside header");

endmodule

bind pulse_width_bus_bit_receiver pwbr_checker u_pwbr_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_event_kind  (m_event_kind),
    .m_bit_value   (m_bit_value),
    .m_bit_index   (m_bit_index),
    .m_data_length (m_data_length)
);

`default_nettype wire
